// ----- hdl/utf8st_pkg.sv -----
// Shared constants, codes and types of the UTF-8 symbol trimmer.
package utf8st_pkg;

	localparam int SYMBOL_MAX = 8;
	localparam int IDX_W      = $clog2(SYMBOL_MAX);
	localparam int KEPT_W     = $clog2(SYMBOL_MAX + 1);
	localparam int LEN_W      = 8;
	localparam int COUNT_W    = 20;
	localparam int LIMIT_W    = 16;

	localparam logic [LEN_W-1:0]  LEN_SAT      = {LEN_W{1'b1}};
	localparam logic [LEN_W-1:0]  SYM_MAX_LEN  = LEN_W'(SYMBOL_MAX);
	localparam logic [KEPT_W-1:0] SYM_MAX_KEPT = KEPT_W'(SYMBOL_MAX);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0]  REG_BYTE_LIMIT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0]  REG_STRICT_MODE = 1'd1;
	localparam logic [LIMIT_W-1:0]    BYTE_LIMIT_RST  = 16'd16;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// byte classes
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;
	// zero width joiner E2 80 8D
	localparam logic [7:0] ZWJ_B0 = 8'hE2;
	localparam logic [7:0] ZWJ_B1 = 8'h80;
	localparam logic [7:0] ZWJ_B2 = 8'h8D;
	// variation selector EF B8 80..8F
	localparam logic [7:0] VS_B0    = 8'hEF;
	localparam logic [7:0] VS_B1    = 8'hB8;
	localparam logic [7:0] VS_B2_LO = 8'h80;
	localparam logic [7:0] VS_B2_HI = 8'h8F;

	// one classified item in the queue
	typedef struct packed {
		logic [7:0] byte_value;
		logic       present;
		logic       eos;
		logic       start;   // byte opens a new symbol
		logic       first;   // byte opens the first symbol of the string
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic emitting;   // draining a kept symbol
		logic appended;   // head item's byte taken, its end still due
	} back_stat_t;

endpackage

// ----- hdl/utf8st_front.sv -----
// Front end: accepts input items and marks symbol boundaries.
module utf8st_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          byte_value,
	input  logic                byte_present,
	input  logic                end_of_string,
	input  utf8st_pkg::fifo_stat_t fifo_stat,
	output logic                push,
	output utf8st_pkg::entry_t  push_data
);
	import utf8st_pkg::*;

	logic at_start_q;

	assign in_ready = !fifo_stat.full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_data.byte_value = byte_value;
		push_data.present    = byte_present;
		push_data.eos        = end_of_string;
		push_data.start      = byte_present &&
			(at_start_q || ((byte_value & CONT_MASK) != CONT_TAG));
		push_data.first      = at_start_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
		end else if (push) begin
			if (end_of_string) begin
				at_start_q <= 1'b1;
			end else if (byte_present) begin
				at_start_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/utf8st_fifo.sv -----
// Short queue of classified items between front and back end.
module utf8st_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  utf8st_pkg::entry_t     push_data,
	input  logic                   pop,
	output utf8st_pkg::entry_t     head,
	output utf8st_pkg::fifo_stat_t stat
);
	import utf8st_pkg::*;

	entry_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + FIFO_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - FIFO_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- hdl/utf8st_back.sv -----
// Back end: symbol buffer, budget count, trim decision and output register.
module utf8st_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  utf8st_pkg::entry_t         head,
	input  utf8st_pkg::fifo_stat_t     fifo_stat,
	output logic                       pop,
	input  logic [utf8st_pkg::LIMIT_W-1:0] byte_limit,
	input  logic                       strict_mode,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic [7:0]                 out_byte,
	output logic                       out_valid,
	output logic                       end_of_output,
	output logic                       symbol_overflow,
	output utf8st_pkg::back_stat_t     stat
);
	import utf8st_pkg::*;

	typedef enum logic {ST_HEAD, ST_EMIT} state_t;

	localparam logic signed [COUNT_W:0] SUM_MAX = {2'b00, {(COUNT_W-1){1'b1}}};
	localparam logic signed [COUNT_W:0] SUM_MIN = {2'b11, {(COUNT_W-1){1'b0}}};

	state_t              state_q;
	logic [7:0]          buf_q [SYMBOL_MAX];
	logic [LEN_W-1:0]    plen_q;
	logic                pfirst_q;
	logic                stopped_q;
	logic [COUNT_W-1:0]  count_q;
	logic                appended_q;
	logic [KEPT_W-1:0]   emit_idx_q;
	logic [KEPT_W-1:0]   emit_last_q;
	logic                emit_ovf_q;
	logic                out_vld_q;
	logic [7:0]          out_byte_q;
	logic                out_valid_q;
	logic                out_eoo_q;
	logic                out_ovf_q;

	logic                have, phase2, fin_need, judge, do_append, slot_free;
	logic                emit_mark, out_load;
	logic                is_zwj, is_vs, keep, stop_now;
	logic signed [COUNT_W:0] weight, sum, sat_sum, limit_ext;
	logic [KEPT_W-1:0]   kept_n;

	assign have      = !fifo_stat.empty;
	// second phase: the byte is in (or absent), only the string end is left
	assign phase2    = appended_q || !head.present;
	assign fin_need  = phase2 ? head.eos : head.start;
	assign judge     = have && (state_q == ST_HEAD) && fin_need && (plen_q != '0);
	assign do_append = have && (state_q == ST_HEAD) && !judge && !phase2;
	assign slot_free = !out_vld_q || res_ready;
	// end marker goes out once the last symbol of the string is settled
	assign emit_mark = have && (state_q == ST_HEAD) && !judge && phase2 && head.eos &&
		slot_free;
	assign out_load  = emit_mark || ((state_q == ST_EMIT) && slot_free);

	always_comb begin
		pop = 1'b0;
		if (have && (state_q == ST_HEAD) && !judge) begin
			if (!phase2) begin
				pop = !head.eos;
			end else begin
				pop = !head.eos || slot_free;
			end
		end
	end

	assign is_zwj = (plen_q == LEN_W'(3)) && (buf_q[0] == ZWJ_B0) &&
		(buf_q[1] == ZWJ_B1) && (buf_q[2] == ZWJ_B2);
	assign is_vs  = (plen_q == LEN_W'(3)) && (buf_q[0] == VS_B0) &&
		(buf_q[1] == VS_B1) && (buf_q[2] >= VS_B2_LO) && (buf_q[2] <= VS_B2_HI);

	always_comb begin
		if (strict_mode || !(is_zwj || is_vs)) begin
			weight = $signed({{(COUNT_W+1-LEN_W){1'b0}}, plen_q});
		end else if (is_zwj) begin
			weight = -(COUNT_W+1)'(3);
		end else begin
			weight = '0;
		end
		sum = $signed({count_q[COUNT_W-1], count_q}) + weight;
		if (sum > SUM_MAX) begin
			sat_sum = SUM_MAX;
		end else if (sum < SUM_MIN) begin
			sat_sum = SUM_MIN;
		end else begin
			sat_sum = sum;
		end
		limit_ext = $signed({{(COUNT_W+1-LIMIT_W){1'b0}}, byte_limit});
		stop_now  = (sat_sum >= limit_ext);
		keep      = !stopped_q && (byte_limit != '0) && (pfirst_q || !stop_now);
		kept_n    = (plen_q < SYM_MAX_LEN) ? plen_q[KEPT_W-1:0] : SYM_MAX_KEPT;
	end

	// symbol buffer; entries beyond the length are never read
	always_ff @(posedge clk) begin
		if (do_append && (plen_q < SYM_MAX_LEN)) begin
			buf_q[plen_q[IDX_W-1:0]] <= head.byte_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_HEAD;
			plen_q      <= '0;
			pfirst_q    <= 1'b0;
			stopped_q   <= 1'b0;
			count_q     <= '0;
			appended_q  <= 1'b0;
			emit_idx_q  <= '0;
			emit_last_q <= '0;
			emit_ovf_q  <= 1'b0;
			out_vld_q   <= 1'b0;
			out_byte_q  <= '0;
			out_valid_q <= 1'b0;
			out_eoo_q   <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (out_vld_q && res_ready && !out_load) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_HEAD: begin
					if (judge) begin
						if (!stopped_q) begin
							if (byte_limit == '0) begin
								stopped_q <= 1'b1;
							end else if (!pfirst_q) begin
								count_q   <= sat_sum[COUNT_W-1:0];
								stopped_q <= stop_now;
							end
						end
						if (keep) begin
							emit_idx_q  <= '0;
							emit_last_q <= kept_n - KEPT_W'(1);
							emit_ovf_q  <= (plen_q > SYM_MAX_LEN);
							state_q     <= ST_EMIT;
						end else begin
							plen_q   <= '0;
							pfirst_q <= 1'b0;
						end
					end else if (do_append) begin
						if (plen_q != LEN_SAT) begin
							plen_q <= plen_q + LEN_W'(1);
						end
						if (head.start) begin
							pfirst_q <= head.first;
						end
						if (head.eos) begin
							appended_q <= 1'b1;
						end
					end else if (emit_mark) begin
						out_vld_q   <= 1'b1;
						out_byte_q  <= '0;
						out_valid_q <= 1'b0;
						out_eoo_q   <= 1'b1;
						out_ovf_q   <= 1'b0;
						stopped_q   <= 1'b0;
						count_q     <= '0;
						plen_q      <= '0;
						pfirst_q    <= 1'b0;
						appended_q  <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_vld_q   <= 1'b1;
						out_byte_q  <= buf_q[emit_idx_q[IDX_W-1:0]];
						out_valid_q <= 1'b1;
						out_eoo_q   <= 1'b0;
						out_ovf_q   <= emit_ovf_q;
						emit_idx_q  <= emit_idx_q + KEPT_W'(1);
						if (emit_idx_q == emit_last_q) begin
							plen_q   <= '0;
							pfirst_q <= 1'b0;
							state_q  <= ST_HEAD;
						end
					end
				end
				default: state_q <= ST_HEAD;
			endcase
		end
	end

	assign res_valid       = out_vld_q;
	assign out_byte        = out_byte_q;
	assign out_valid       = out_valid_q;
	assign end_of_output   = out_eoo_q;
	assign symbol_overflow = out_ovf_q;
	assign stat.emitting   = (state_q == ST_EMIT);
	assign stat.appended   = appended_q;

endmodule

// ----- hdl/utf8_symbol_trimmer_top.sv -----
// Top level of the UTF-8 symbol trimmer: config registers, front, queue, back.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | byte_value, byte_present, end_of_string
//  result  | res_valid / res_ready| out_byte, out_valid, end_of_output, symbol_overflow
//  config  | cfg_we (no wait)     | cfg_index, cfg_data
//
// The front takes one item per cycle while the 4-entry queue has room.
// The back takes the queued items in turn; a byte that opens a new symbol, or
// the end of the string, first has the pending symbol judged against the budget and
// its kept bytes (up to SYMBOL_MAX) emitted, and an end of string then sends the marker.
// Reset clears all control state at once; no clearing pass is needed.
// A stalled result holds the back only; the front keeps filling the queue.
module utf8_symbol_trimmer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// input items
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        byte_value,
	input  logic                              byte_present,
	input  logic                              end_of_string,
	// result items
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [7:0]                        out_byte,
	output logic                              out_valid,
	output logic                              end_of_output,
	output logic                              symbol_overflow,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [utf8st_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [utf8st_pkg::CFG_DATA_W-1:0] cfg_data
);
	import utf8st_pkg::*;

	logic [LIMIT_W-1:0] byte_limit_q;
	logic               strict_mode_q;

	logic       push, pop;
	entry_t     push_data, head;
	fifo_stat_t fifo_stat;
	back_stat_t back_stat;

	// Registers are to be written by the user only while the block is idle, so the back end
	// sees a steady limit and mode for every symbol it judges; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_limit_q  <= BYTE_LIMIT_RST;
			strict_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BYTE_LIMIT:  byte_limit_q  <= cfg_data[LIMIT_W-1:0];
				REG_STRICT_MODE: strict_mode_q <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	// Front: tags each byte as symbol start / first symbol of the string.
	utf8st_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.byte_value    (byte_value),
		.byte_present  (byte_present),
		.end_of_string (end_of_string),
		.fifo_stat     (fifo_stat),
		.push          (push),
		.push_data     (push_data)
	);

	// Queue decouples input acceptance from symbol emission bursts.
	utf8st_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (fifo_stat)
	);

	// Back: buffers the pending symbol, updates the count, emits or drops it.
	// The head item stays in the queue until all of its work is done.
	utf8st_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.fifo_stat       (fifo_stat),
		.pop             (pop),
		.byte_limit      (byte_limit_q),
		.strict_mode     (strict_mode_q),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.out_byte        (out_byte),
		.out_valid       (out_valid),
		.end_of_output   (end_of_output),
		.symbol_overflow (symbol_overflow),
		.stat            (back_stat)
	);

	// The end marker never carries a byte or an overflow flag.
	a_marker_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && end_of_output |-> !out_valid && (out_byte == 8'h00) && !symbol_overflow)
		else $error("end marker carries payload");

	// Overflow is only ever flagged on kept bytes.
	a_ovf_on_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && symbol_overflow |-> out_valid && !end_of_output)
		else $error("overflow flag outside a kept byte");

	// While the back is mid-item, that item must still sit at the queue head.
	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.emitting || back_stat.appended |-> !fifo_stat.empty)
		else $error("head item popped before its work finished");

	// No pop may happen while a kept symbol is being drained.
	a_no_pop_emit: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.emitting |-> !pop)
		else $error("queue popped during emission");

endmodule
